[hdl/hrdp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID report descriptor parser package
// Shared types, item codes and helpers for the parser front, queue and back.
// ----------------------------------------------------------------------------
package hrdp_pkg;

    localparam int unsigned USAGE_DEPTH_DEF  = 32;
    localparam int unsigned MAX_ELEMENTS_DEF = 64;
    localparam int unsigned OUT_W            = 208;

    localparam logic [1:0] TYPE_MAIN   = 2'd0;
    localparam logic [1:0] TYPE_GLOBAL = 2'd1;
    localparam logic [1:0] TYPE_LOCAL  = 2'd2;
    localparam logic [1:0] TYPE_RSVD   = 2'd3;

    localparam logic [3:0] TAG_NOP      = 4'h0;
    localparam logic [3:0] TAG_INPUT    = 4'h8;
    localparam logic [3:0] TAG_COLL     = 4'hA;
    localparam logic [3:0] TAG_END_COLL = 4'hC;
    localparam logic [3:0] TAG_LONG     = 4'hF;
    localparam logic [3:0] TAG_PAGE     = 4'h0;
    localparam logic [3:0] TAG_RSIZE    = 4'h7;
    localparam logic [3:0] TAG_RID      = 4'h8;
    localparam logic [3:0] TAG_RCOUNT   = 4'h9;
    localparam logic [3:0] TAG_USAGE    = 4'h0;
    localparam logic [3:0] TAG_UMIN     = 4'h1;
    localparam logic [3:0] TAG_UMAX     = 4'h2;

    typedef struct packed {
        logic        clr;
        logic [7:0]  hdr;
        logic [31:0] value;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELEM,
        S_RDW,
        S_BASE_RD,
        S_BASE_WR
    } t_state;

    function automatic logic [2:0] data_len(input logic [1:0] code);
        logic [2:0] len;
        case (code)
            2'd0:    len = 3'd0;
            2'd1:    len = 3'd1;
            2'd2:    len = 3'd2;
            default: len = 3'd4;
        endcase
        return len;
    endfunction

endpackage

[hdl/hid_report_descriptor_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID report descriptor parser
// Parses short items of a report descriptor and emits Input field beats.
// ----------------------------------------------------------------------------
// Descriptor bytes are taken one per cycle into an item assembler and queued
// as complete items in a two-entry queue; the input stalls while that queue
// is full. The executor first clears its state for an item that carries the
// first-byte clear, then applies each global, local or non-Input main item.
// An Input item is taken, then each field either repeats the usage of the
// previous field or reads it from the usage ring (its read data is
// registered, so the field waits in a read state), and the ring base is then
// moved by a read step and a write step, also for a zero count. Output beats
// wait in one register, and the executor emits the next field only once the
// sink has taken the pending beat.
// ----------------------------------------------------------------------------
module hid_report_descriptor_parser import hrdp_pkg::*; #(
    parameter int unsigned USAGE_DEPTH  = USAGE_DEPTH_DEF,
    parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    input  logic [7:0]       i_s_axis_tdata,   // [7:0] desc_byte
    input  logic [0:0]       i_s_axis_tuser,   // [0] first_byte
    output logic             o_s_axis_tready,
    output logic             o_m_axis_tvalid,
    // [15:0] bit_offset, [31:16] field_bits, [63:32] usage, [95:64] cur_page,
    // [127:96] usage_minimum, [159:128] usage_maximum, [160] is_constant,
    // [161] is_variable, [169:162] rpt_id, [201:170] top_usage, rest zero
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast,   // last_of_run
    input  logic             i_m_axis_tready
);

    logic  push, full, qvalid, pop;
    t_item push_item, head_item;

    hrdp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_s_axis_tready (o_s_axis_tready),
        .i_full          (full),
        .o_push          (push),
        .o_item          (push_item)
    );

    hrdp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (qvalid),
        .o_item  (head_item)
    );

    hrdp_back #(
        .USAGE_DEPTH  (USAGE_DEPTH),
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (qvalid),
        .i_item          (head_item),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_m_axis_tready (i_m_axis_tready)
    );

endmodule

[hdl/hrdp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID parser front
// Assembles header and little-endian data bytes into complete short items.
// ----------------------------------------------------------------------------
module hrdp_front import hrdp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] desc_byte
    input  logic [0:0] i_s_axis_tuser,   // [0] first_byte
    output logic       o_s_axis_tready,
    input  logic       i_full,
    output logic       o_push,
    output t_item      o_item
);

    logic [2:0]  r_left, n_left;
    logic [7:0]  r_hdr, n_hdr;
    logic [31:0] r_val, n_val;
    logic        r_clr, n_clr;

    logic        accept;
    logic [2:0]  left;
    logic        clr;
    logic [2:0]  len;
    logic [1:0]  pos;
    logic [31:0] val;

    assign o_s_axis_tready = !i_full;
    assign accept = i_s_axis_tvalid && !i_full;

    always_comb begin
        left   = i_s_axis_tuser[0] ? 3'd0 : r_left;
        clr    = i_s_axis_tuser[0] | r_clr;
        len    = data_len(i_s_axis_tdata[1:0]);
        pos    = 2'(data_len(r_hdr[1:0]) - left);
        val    = r_val | (32'(i_s_axis_tdata) << {pos, 3'b000});
        n_left = r_left;
        n_hdr  = r_hdr;
        n_val  = r_val;
        n_clr  = r_clr;
        o_push = 1'b0;
        o_item = '{clr: clr, hdr: r_hdr, value: val};
        if (accept) begin
            if (left == 3'd0) begin
                n_hdr  = i_s_axis_tdata;
                n_val  = '0;
                n_left = len;
                if (len == 3'd0) begin
                    o_push = 1'b1;
                    o_item = '{clr: clr, hdr: i_s_axis_tdata, value: 32'd0};
                    n_clr  = 1'b0;
                end else begin
                    n_clr  = clr;
                end
            end else begin
                n_val  = val;
                n_left = left - 3'd1;
                if (left == 3'd1) begin
                    o_push = 1'b1;
                    n_clr  = 1'b0;
                end else begin
                    n_clr  = clr;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_val <= n_val;
        if (!i_rst_n) begin
            r_left <= '0;
            r_clr  <= 1'b0;
        end else begin
            r_left <= n_left;
            r_clr  <= n_clr;
        end
    end

endmodule

[hdl/hrdp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID parser item queue
// Two-entry queue between the byte assembler and the item executor.
// ----------------------------------------------------------------------------
module hrdp_queue import hrdp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr;
    logic       rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
    end

endmodule

[hdl/hrdp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID parser back
// Executes items: global and local state, usage ring, Input field beats.
// ----------------------------------------------------------------------------
module hrdp_back import hrdp_pkg::*; #(
    parameter int unsigned USAGE_DEPTH  = USAGE_DEPTH_DEF,
    parameter int unsigned MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_item            i_item,
    output logic             o_pop,
    output logic             o_m_axis_tvalid,
    output logic [OUT_W-1:0] o_m_axis_tdata,
    output logic             o_m_axis_tlast,
    input  logic             i_m_axis_tready
);

    localparam int unsigned AW = $clog2(USAGE_DEPTH);
    localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(USAGE_DEPTH);
    localparam logic [AW-1:0] LAST_POS = AW'(USAGE_DEPTH - 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_ELEMENTS);

    t_state r_state, n_state;

    logic [31:0]   r_page, r_size, r_count, r_min, r_max, r_outer, r_prev;
    logic [7:0]    r_rid, r_open, r_close;
    logic [AW-1:0] r_base, r_pend, r_pos;
    logic [15:0]   r_off, r_fsize;
    logic [CW-1:0] r_i, r_n;
    logic [1:0]    r_flags;
    logic          r_clr_done;

    logic [31:0]   r_ring [USAGE_DEPTH];
    logic          r_vld [USAGE_DEPTH];
    logic [31:0]   r_rd;
    logic          r_rd_vld;

    logic             r_ovalid;
    logic [OUT_W-1:0] r_odata;
    logic             r_olast;

    logic [1:0]    typ;
    logic [3:0]    tag;
    logic          equal;
    logic [AW:0]   sum;
    logic [AW-1:0] wpos;
    logic          merged;
    logic [CW-1:0] sat, cnt;
    logic [15:0]   fsize;
    logic          out_free;
    logic          copy;
    logic          last;
    logic [31:0]   rd_val;
    logic          do_clear, emit, we;
    logic [AW-1:0] wa, ra;
    logic [31:0]   wd, usage_now;
    logic          ring_room;
    logic          is_input;

    always_comb begin
        typ      = i_item.hdr[3:2];
        tag      = i_item.hdr[7:4];
        equal    = (r_open == r_close);
        sum      = {1'b0, r_base} + {1'b0, r_pend};
        wpos     = (sum >= DEPTH_W) ? AW'(sum - DEPTH_W) : AW'(sum);
        merged   = (r_size == 32'd1) && (9'(r_pend) <= 9'd1);
        sat      = (r_count > 32'(MAX_ELEMENTS)) ? MAX_CNT : r_count[CW-1:0];
        cnt      = merged ? CW'(1) : sat;
        fsize    = merged ? r_count[15:0] : r_size[15:0];
        out_free = !r_ovalid || i_m_axis_tready;
        copy     = (r_i != '0) && (9'(r_i) >= 9'(r_pend)) && (int'(r_i) < USAGE_DEPTH);
        last     = (r_i == r_n - CW'(1));
        rd_val   = r_rd_vld ? r_rd : 32'd0;
        ring_room = 9'(r_pend) < 9'(USAGE_DEPTH - 1);
        is_input = (typ == TYPE_MAIN) && (tag == TAG_INPUT);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !(i_item.clr && !r_clr_done) && is_input) begin
                    n_state = (cnt == '0) ? S_BASE_RD : S_ELEM;
                end
            end
            S_ELEM: begin
                if (!copy) begin
                    n_state = S_RDW;
                end else if (out_free) begin
                    n_state = last ? S_BASE_RD : S_ELEM;
                end
            end
            S_RDW: begin
                if (out_free) begin
                    n_state = last ? S_BASE_RD : S_ELEM;
                end
            end
            S_BASE_RD: n_state = S_BASE_WR;
            S_BASE_WR: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        do_clear  = 1'b0;
        o_pop     = 1'b0;
        emit      = 1'b0;
        we        = 1'b0;
        wa        = wpos;
        wd        = i_item.value;
        ra        = r_pos;
        usage_now = r_prev;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_item.clr && !r_clr_done) begin
                        do_clear = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                        we = (typ == TYPE_LOCAL) && (tag == TAG_USAGE) && !equal
                             && ring_room;
                    end
                end
            end
            S_ELEM: begin
                if (copy && out_free) begin
                    emit = 1'b1;
                    we   = 1'b1;
                    wa   = r_pos;
                    wd   = r_prev;
                end
            end
            S_RDW: begin
                usage_now = rd_val;
                emit      = out_free;
            end
            S_BASE_RD: begin
                ra = r_base;
            end
            S_BASE_WR: begin
                we = 1'b1;
                wd = rd_val;
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_ring[wa] <= wd;
        end
        r_rd     <= r_ring[ra];
        r_rd_vld <= r_vld[ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_clear) begin
            for (int k = 0; k < USAGE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (we) begin
            r_vld[wa] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || do_clear) begin
            r_page  <= '0;
            r_size  <= '0;
            r_count <= '0;
            r_rid   <= '0;
            r_min   <= '0;
            r_max   <= '0;
            r_base  <= '0;
            r_pend  <= '0;
            r_open  <= '0;
            r_close <= '0;
            r_off   <= '0;
            r_outer <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (typ)
                            TYPE_MAIN: begin
                                if (equal) begin
                                    r_off <= '0;
                                end
                                if (tag == TAG_COLL) begin
                                    r_open <= r_open + 8'd1;
                                end else if (tag == TAG_END_COLL) begin
                                    r_close <= r_close + 8'd1;
                                end
                                if (tag != TAG_INPUT) begin
                                    r_pend <= '0;
                                    r_min  <= '0;
                                    r_max  <= '0;
                                end
                            end
                            TYPE_GLOBAL: begin
                                if (tag == TAG_PAGE) begin
                                    r_page <= i_item.value;
                                end else if (tag == TAG_RSIZE) begin
                                    r_size <= i_item.value;
                                end else if (tag == TAG_RID) begin
                                    r_rid <= i_item.value[7:0];
                                end else if (tag == TAG_RCOUNT) begin
                                    r_count <= i_item.value;
                                end
                            end
                            TYPE_LOCAL: begin
                                if (tag == TAG_USAGE) begin
                                    if (equal) begin
                                        r_outer <= i_item.value;
                                    end else if (ring_room) begin
                                        r_pend <= r_pend + AW'(1);
                                    end
                                end else if (tag == TAG_UMIN) begin
                                    r_min <= i_item.value;
                                end else if (tag == TAG_UMAX) begin
                                    r_max <= i_item.value;
                                end
                            end
                            default: begin
                                r_pend <= r_pend;
                            end
                        endcase
                    end
                end
                S_BASE_WR: begin
                    r_base <= wpos;
                    r_pend <= '0;
                    r_min  <= '0;
                    r_max  <= '0;
                end
                default: begin
                    if (emit) begin
                        r_off <= r_off + r_fsize;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_i     <= '0;
            r_n     <= cnt;
            r_pos   <= r_base;
            r_fsize <= fsize;
            r_flags <= i_item.value[1:0];
        end else if (emit) begin
            r_i    <= r_i + CW'(1);
            r_pos  <= (r_pos == LAST_POS) ? '0 : r_pos + AW'(1);
            r_prev <= usage_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr_done <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_clear) begin
                r_clr_done <= 1'b1;
            end else if (o_pop) begin
                r_clr_done <= 1'b0;
            end
            if (out_free) begin
                r_ovalid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_odata <= {6'd0, r_outer, r_rid, r_flags[1], r_flags[0], r_max, r_min,
                        r_page, usage_now, r_fsize, r_off};
            r_olast <= last;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tlast  = r_olast;

endmodule

[hdl/hrdp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID parser port checker
// Watches the stream ports for handshake and field layout consistency.
// ----------------------------------------------------------------------------
module hrdp_checker import hrdp_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic [7:0]       i_s_axis_tdata,
    input logic [0:0]       i_s_axis_tuser,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic [OUT_W-1:0] o_m_axis_tdata,
    input logic             o_m_axis_tlast,
    input logic             i_m_axis_tready
);

    logic        r_in_run;
    logic [15:0] r_exp_off;
    logic [31:0] r_page;
    logic        beat;

    assign beat = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
        end else if (beat) begin
            r_in_run <= !o_m_axis_tlast;
        end
        if (beat) begin
            r_exp_off <= o_m_axis_tdata[15:0] + o_m_axis_tdata[31:16];
            r_page    <= o_m_axis_tdata[95:64];
        end
    end

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata)
        && $stable(o_m_axis_tlast))
        else $error("output beat changed while stalled");

    a_run_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat && r_in_run |-> o_m_axis_tdata[15:0] == r_exp_off
        && o_m_axis_tdata[95:64] == r_page)
        else $error("field offset or page broken inside a run");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind hid_report_descriptor_parser hrdp_checker u_hrdp_checker (.*);

[tb/sv/tb_hid_report_descriptor_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HID report descriptor parser testbench
// Streams directed and random descriptors into the parser, predicts every
// field beat from a behavioral copy of the parser state, and checks each
// output beat field by field under random source and sink stalls.
// ----------------------------------------------------------------------------
module tb_hid_report_descriptor_parser;
    import hrdp_pkg::*;

    typedef struct packed {
        logic [15:0] bit_offset;
        logic [15:0] field_bits;
        logic [31:0] usage;
        logic [31:0] cur_page;
        logic [31:0] usage_minimum;
        logic [31:0] usage_maximum;
        logic        is_constant;
        logic        is_variable;
        logic [7:0]  rpt_id;
        logic [31:0] top_usage;
        logic        last_of_run;
    } t_field;

    class field_scoreboard;
        logic [7:0]  hdr;
        logic [2:0]  bytes_left;
        logic [31:0] value;
        logic [31:0] page;
        logic [31:0] rsize;
        logic [31:0] rcount;
        logic [7:0]  rid;
        logic [31:0] umin;
        logic [31:0] umax;
        logic [31:0] ring [USAGE_DEPTH_DEF];
        logic [4:0]  base;
        logic [5:0]  pending;
        logic [7:0]  opened;
        logic [7:0]  closed;
        logic [15:0] offset;
        logic [31:0] outer;
        t_field      fields_due[$];
        int          errors;

        function void clear();
            hdr = 0; bytes_left = 0; value = 0; page = 0; rsize = 0; rcount = 0;
            rid = 0; umin = 0; umax = 0; base = 0; pending = 0; opened = 0;
            closed = 0; offset = 0; outer = 0;
            foreach (ring[k]) ring[k] = 0;
        endfunction

        function logic [4:0] pos(int unsigned i);
            return base + 5'(i % USAGE_DEPTH_DEF);
        endfunction

        function void expand_input();
            logic [31:0] sz;
            logic [31:0] cnt;
            logic [4:0]  old_base;
            t_field      f;
            sz = rsize;
            cnt = rcount;
            if (sz == 1 && pending <= 1) begin
                sz = cnt;
                cnt = 1;
            end
            if (cnt > MAX_ELEMENTS_DEF) cnt = MAX_ELEMENTS_DEF;
            for (int unsigned i = 0; i < cnt; i++) begin
                if (i > 0 && i >= pending && i < USAGE_DEPTH_DEF)
                    ring[pos(i)] = ring[pos(i - 1)];
                f.bit_offset = offset;
                f.field_bits = sz[15:0];
                f.usage = ring[pos(i)];
                f.cur_page = page;
                f.usage_minimum = umin;
                f.usage_maximum = umax;
                f.is_constant = value[0];
                f.is_variable = value[1];
                f.rpt_id = rid;
                f.top_usage = outer;
                f.last_of_run = (i + 1 == cnt);
                fields_due.push_back(f);
                offset = offset + sz[15:0];
            end
            old_base = base;
            base = base + pending[4:0];
            ring[base] = ring[old_base];
        endfunction

        function void execute_item();
            logic [1:0] ty;
            logic [3:0] tg;
            ty = hdr[3:2];
            tg = hdr[7:4];
            if (ty == TYPE_MAIN) begin
                if (opened == closed) offset = 0;
                if (tg == TAG_COLL) opened++;
                else if (tg == TAG_END_COLL) closed++;
                else if (tg == TAG_INPUT) expand_input();
                pending = 0; umin = 0; umax = 0;
            end else if (ty == TYPE_GLOBAL) begin
                if (tg == TAG_PAGE) page = value;
                else if (tg == TAG_RSIZE) rsize = value;
                else if (tg == TAG_RID) rid = value[7:0];
                else if (tg == TAG_RCOUNT) rcount = value;
            end else if (ty == TYPE_LOCAL) begin
                if (tg == TAG_USAGE) begin
                    if (opened == closed) outer = value;
                    else if (pending < USAGE_DEPTH_DEF - 1) begin
                        ring[pos(pending)] = value;
                        pending++;
                    end
                end else if (tg == TAG_UMIN) umin = value;
                else if (tg == TAG_UMAX) umax = value;
            end
        endfunction

        function void note_byte(logic [7:0] b, logic first);
            if (first) clear();
            if (bytes_left == 0) begin
                hdr = b;
                value = 0;
                bytes_left = data_len(b[1:0]);
                if (bytes_left == 0) execute_item();
            end else begin
                value |= 32'(b) << (8 * ((data_len(hdr[1:0]) - bytes_left) & 3));
                bytes_left--;
                if (bytes_left == 0) execute_item();
            end
        endfunction

        function void check_field(t_field got);
            t_field exp;
            if (fields_due.size() == 0) begin
                $error("unexpected beat %h", got);
                errors++;
                return;
            end
            exp = fields_due.pop_front();
            if (got.bit_offset !== exp.bit_offset) begin
                $error("bit_offset exp %h got %h", exp.bit_offset, got.bit_offset); errors++;
            end
            if (got.field_bits !== exp.field_bits) begin
                $error("field_bits exp %h got %h", exp.field_bits, got.field_bits); errors++;
            end
            if (got.usage !== exp.usage) begin
                $error("usage exp %h got %h", exp.usage, got.usage); errors++;
            end
            if (got.cur_page !== exp.cur_page) begin
                $error("cur_page exp %h got %h", exp.cur_page, got.cur_page); errors++;
            end
            if (got.usage_minimum !== exp.usage_minimum) begin
                $error("usage_minimum exp %h got %h", exp.usage_minimum, got.usage_minimum);
                errors++;
            end
            if (got.usage_maximum !== exp.usage_maximum) begin
                $error("usage_maximum exp %h got %h", exp.usage_maximum, got.usage_maximum);
                errors++;
            end
            if (got.is_constant !== exp.is_constant) begin
                $error("is_constant exp %b got %b", exp.is_constant, got.is_constant); errors++;
            end
            if (got.is_variable !== exp.is_variable) begin
                $error("is_variable exp %b got %b", exp.is_variable, got.is_variable); errors++;
            end
            if (got.rpt_id !== exp.rpt_id) begin
                $error("rpt_id exp %h got %h", exp.rpt_id, got.rpt_id); errors++;
            end
            if (got.top_usage !== exp.top_usage) begin
                $error("top_usage exp %h got %h", exp.top_usage, got.top_usage); errors++;
            end
            if (got.last_of_run !== exp.last_of_run) begin
                $error("last_of_run exp %b got %b", exp.last_of_run, got.last_of_run); errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             s_tvalid;
    logic [7:0]       s_tdata;
    logic [0:0]       s_tuser;
    logic             s_tready;
    logic             m_tvalid;
    logic [OUT_W-1:0] m_tdata;
    logic             m_tlast;
    logic             m_tready;

    field_scoreboard  sb;
    bit               sink_hold;
    bit               src_done;
    int               idle_cycles;
    logic [7:0]       byte_q[$];
    logic             first_q[$];

    hid_report_descriptor_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_s_axis_tready (s_tready),
        .o_m_axis_tvalid (m_tvalid),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .i_m_axis_tready (m_tready)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // queue an item: header plus little-endian data
    task automatic add_item(logic [1:0] ty, logic [3:0] tg, logic [1:0] sz,
                            logic [31:0] val, logic first = 0);
        byte_q.push_back({tg, ty, sz});
        first_q.push_back(first);
        for (int k = 0; k < data_len(sz); k++) begin
            byte_q.push_back(val[8 * k +: 8]);
            first_q.push_back(1'b0);
        end
    endtask

    task automatic send_queued();
        int gap;
        while (byte_q.size() > 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= byte_q.pop_front();
            s_tuser  <= first_q.pop_front();
            @(posedge i_clk);
            while (!s_tready) @(posedge i_clk);
            sb.note_byte(s_tdata, s_tuser[0]);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.fields_due.size() > 0) @(posedge i_clk);
    endtask

    function automatic logic [1:0] rand_size();
        return 2'($urandom_range(0, 3));
    endfunction

    // random descriptor with random content; its collection is not always closed
    task automatic add_descriptor();
        int n;
        add_item(TYPE_GLOBAL, TAG_PAGE, rand_size(), $urandom, 1'b1);
        if ($urandom_range(0, 1)) add_item(TYPE_GLOBAL, TAG_RID, 2'd1, $urandom);
        add_item(TYPE_LOCAL, TAG_USAGE, 2'd1, $urandom);
        add_item(TYPE_MAIN, TAG_COLL, 2'd1, 1);
        n = $urandom_range(1, 3);
        for (int k = 0; k < n; k++) begin
            repeat ($urandom_range(0, 4)) add_item(TYPE_LOCAL, TAG_USAGE, rand_size(), $urandom);
            if ($urandom_range(0, 2) == 0) begin
                add_item(TYPE_LOCAL, TAG_UMIN, rand_size(), $urandom);
                add_item(TYPE_LOCAL, TAG_UMAX, rand_size(), $urandom);
            end
            add_item(TYPE_GLOBAL, TAG_RSIZE, 2'd1,
                     $urandom_range(0, 1) ? 1 : $urandom_range(0, 16));
            add_item(TYPE_GLOBAL, TAG_RCOUNT, 2'd1,
                     ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255)
                                                  : $urandom_range(0, 6));
            add_item(TYPE_MAIN, TAG_INPUT, 2'd1, $urandom_range(0, 255));
        end
        if ($urandom_range(0, 4) != 0) add_item(TYPE_MAIN, TAG_END_COLL, 2'd0, 0);
    endtask

    initial begin
        int sent;
        sb = new();
        sb.clear();
        sb.errors = 0;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tuser  <= 1'b0;
        src_done = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every item kind, special cases
        add_item(TYPE_GLOBAL, TAG_PAGE, 2'd3, 32'hFFFF_FFFF, 1'b1);
        add_item(TYPE_LOCAL, TAG_USAGE, 2'd2, 32'h0000_ABCD);   // outside collection
        add_item(TYPE_GLOBAL, TAG_RID, 2'd2, 32'h0000_12FF);
        add_item(TYPE_MAIN, TAG_COLL, 2'd1, 1);
        add_item(TYPE_LOCAL, TAG_USAGE, 2'd3, 32'h8000_0001);
        add_item(TYPE_LOCAL, TAG_UMIN, 2'd3, 32'hFFFF_FFFF);
        add_item(TYPE_LOCAL, TAG_UMAX, 2'd1, 32'h0000_00FF);
        add_item(TYPE_GLOBAL, TAG_RSIZE, 2'd1, 1);
        add_item(TYPE_GLOBAL, TAG_RCOUNT, 2'd1, 8);              // merged 1-bit run
        add_item(TYPE_MAIN, TAG_INPUT, 2'd1, 3);
        add_item(TYPE_GLOBAL, TAG_RSIZE, 2'd2, 16'hFFFF);
        add_item(TYPE_GLOBAL, TAG_RCOUNT, 2'd3, 32'hFFFF_FFFF);  // saturates
        add_item(TYPE_MAIN, TAG_INPUT, 2'd0, 0);
        add_item(TYPE_GLOBAL, TAG_RCOUNT, 2'd0, 0);              // zero count
        add_item(TYPE_MAIN, TAG_INPUT, 2'd1, 2);
        add_item(TYPE_RSVD, TAG_LONG, 2'd2, 32'h0000_FFFF);      // reserved type
        add_item(TYPE_MAIN, TAG_END_COLL, 2'd0, 0);
        send_queued();
        wait_drained();

        // ring overflow: many usages inside a collection
        add_item(TYPE_MAIN, TAG_COLL, 2'd1, 0, 1'b1);
        for (int k = 0; k < 34; k++) add_item(TYPE_LOCAL, TAG_USAGE, 2'd1, k + 1);
        add_item(TYPE_GLOBAL, TAG_RSIZE, 2'd1, 2);
        add_item(TYPE_GLOBAL, TAG_RCOUNT, 2'd1, 40);
        add_item(TYPE_MAIN, TAG_INPUT, 2'd1, 2);
        add_item(TYPE_LOCAL, TAG_USAGE, 2'd1, 8'h77);
        add_item(TYPE_MAIN, TAG_INPUT, 2'd1, 1);
        send_queued();

        // sink hold-off while the source keeps streaming
        sink_hold = 1;
        add_descriptor();
        add_descriptor();
        send_queued();
        wait_drained();

        sent = 0;
        while (sent < 190) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    byte_q.push_back(8'($urandom));
                    first_q.push_back(1'($urandom_range(0, 7) == 0));
                end
            end else begin
                add_descriptor();
            end
            sent += byte_q.size();
            send_queued();
            if ($urandom_range(0, 5) == 0) wait_drained();
        end
        // flush any partial item so nothing stays in the assembler
        add_item(TYPE_MAIN, TAG_NOP, 2'd0, 0, 1'b1);
        send_queued();
        wait_drained();
        src_done = 1;
    end

    // sink: random stalls, one long hold-off
    initial begin
        int gap;
        m_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
                sink_hold = 0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready)
            sb.check_field({m_tdata[15:0], m_tdata[31:16], m_tdata[63:32], m_tdata[95:64],
                            m_tdata[127:96], m_tdata[159:128], m_tdata[160], m_tdata[161],
                            m_tdata[169:162], m_tdata[201:170], m_tlast});
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (src_done) begin
                repeat (300) @(posedge i_clk);
                if (sb.errors == 0 && sb.fields_due.size() == 0)
                    $display("hid_report_descriptor_parser regression: pass");
                else
                    $display("hid_report_descriptor_parser regression: fail");
                $finish;
            end else if (idle_cycles > 5000) begin
                $display("hid_report_descriptor_parser regression: fail");
                $finish;
            end
        end
    end

endmodule
